// File: hw/rtl/ddp_short_long_header_converter_assert.svh
// Assertion macros for the header converter; empty under synthesis.
`ifndef DDP_SHORT_LONG_HEADER_CONVERTER_ASSERT_SVH
`define DDP_SHORT_LONG_HEADER_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SLHC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define SLHC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SLHC_ASSERT(name, prop, msg)
`define SLHC_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// File: hw/rtl/ddp_slhc_pkg.sv
package ddp_slhc_pkg;

  // Room for the results of one input byte, and the width of a count of them
  localparam int MAX_RESULTS = 10;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [10:0] POS_MAX     = 11'h7ff;
  localparam logic [10:0] LIMIT_RESET = 11'h7ff;
  localparam logic [7:0]  NBP_TYPE    = 8'd2;
  localparam logic [7:0]  BCAST_NODE  = 8'hff;
  localparam logic [3:0]  COUNT_MASK  = 4'hf;
  localparam logic [9:0]  HDR_DELTA   = 10'd8;

  // One input transaction: a packet byte plus the long header addresses
  typedef struct packed {
    logic        op;
    logic [7:0]  in_byte;
    logic        in_last;
    logic [7:0]  dst_node;
    logic [15:0] dst_net;
    logic [7:0]  source_node;
    logic [15:0] src_net;
  } in_t;

  // One output transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_status;
  } out_t;

  // All results caused by one input byte, first result at index 0
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    out_t [MAX_RESULTS-1:0]       items;
  } res_set_t;

endpackage

// File: hw/rtl/ddp_slhc_core.sv
module ddp_slhc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  ddp_slhc_pkg::in_t     item,
  input  logic [10:0]           out_limit,
  output ddp_slhc_pkg::res_set_t res
);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_ID,
    PH_NET_HI,
    PH_NET_LO,
    PH_NODE,
    PH_SOCKET,
    PH_ENUM,
    PH_NAMES
  } nbp_phase_t;

  // Byte positions of interest in the incoming header
  localparam logic [10:0] POS_LEN_HI = 11'd0;
  localparam logic [10:0] POS_LEN_LO = 11'd1;
  localparam logic [10:0] POS_S_DSK  = 11'd2;
  localparam logic [10:0] POS_S_SSK  = 11'd3;
  localparam logic [10:0] POS_S_TYPE = 11'd4;
  localparam logic [10:0] POS_L_DSK  = 11'd10;
  localparam logic [10:0] POS_L_SSK  = 11'd11;
  localparam logic [10:0] POS_L_TYPE = 11'd12;

  // Packet state
  logic [10:0] pos, pos_next;
  logic [9:0]  packet_length, packet_length_next;
  logic        direction_held, direction_held_next;
  logic        rejecting, rejecting_next;
  logic        is_nbp, is_nbp_next;
  nbp_phase_t  nbp_phase, nbp_phase_next;
  logic [3:0]  tuples_left, tuples_left_next;
  logic [7:0]  name_bytes_left, name_bytes_left_next;
  logic [1:0]  names_left, names_left_next;
  logic [15:0] tuple_net, tuple_net_next;
  logic [7:0]  dnode, dnode_next, snode, snode_next;
  logic [15:0] dnet, dnet_next, snet, snet_next;

  // NBP walk candidates
  nbp_phase_t  n_phase;
  logic [3:0]  n_tuples, tl_dec;
  logic [7:0]  n_nbl, nbp_out;
  logic [1:0]  n_names, names_dec;
  logic        n_is_nbp, tuple_end;

  // Result assembly
  logic [9:0]                       pl_full;
  logic [10:0]                      nl;
  logic                             reject_now, end_pkt, mark_last;
  logic [ddp_slhc_pkg::CNT_W-1:0]   k;
  ddp_slhc_pkg::out_t [ddp_slhc_pkg::MAX_RESULTS-1:0] items;

  // Walk one byte of the NBP tuple list
  always_comb begin
    nbp_out   = item.in_byte;
    n_phase   = nbp_phase;
    n_tuples  = tuples_left;
    n_nbl     = name_bytes_left;
    n_names   = names_left;
    n_is_nbp  = is_nbp;
    tuple_end = 1'b0;
    tl_dec    = tuples_left - 4'd1;
    names_dec = names_left - 2'd1;
    case (nbp_phase)
      PH_COUNT: begin
        n_tuples = item.in_byte[3:0] & ddp_slhc_pkg::COUNT_MASK;
        if (n_tuples == 4'd0) n_is_nbp = 1'b0;
        else n_phase = PH_ID;
      end
      PH_ID:     n_phase = PH_NET_HI;
      PH_NET_HI: begin
        n_phase = PH_NET_LO;
        nbp_out = tuple_net[15:8];
      end
      PH_NET_LO: begin
        n_phase = PH_NODE;
        nbp_out = tuple_net[7:0];
      end
      PH_NODE:   n_phase = PH_SOCKET;
      PH_SOCKET: n_phase = PH_ENUM;
      PH_ENUM: begin
        n_phase = PH_NAMES;
        n_names = 2'd3;
        n_nbl   = 8'd0;
      end
      PH_NAMES: begin
        if (name_bytes_left == 8'd0) begin
          n_names   = names_dec;
          n_nbl     = item.in_byte;
          tuple_end = (item.in_byte == 8'd0) && (names_dec == 2'd0);
        end else begin
          n_nbl     = name_bytes_left - 8'd1;
          tuple_end = (name_bytes_left == 8'd1) && (names_left == 2'd0);
        end
      end
      default: ;
    endcase
    // Advance to the next tuple or leave the walk
    if (tuple_end) begin
      n_tuples = tl_dec;
      if (tl_dec == 4'd0) n_is_nbp = 1'b0;
      else n_phase = PH_NET_HI;
    end
  end

  // Convert one byte and work out the next packet state
  always_comb begin
    pos_next             = pos;
    packet_length_next   = packet_length;
    direction_held_next  = direction_held;
    rejecting_next       = rejecting;
    is_nbp_next          = is_nbp;
    nbp_phase_next       = nbp_phase;
    tuples_left_next     = tuples_left;
    name_bytes_left_next = name_bytes_left;
    names_left_next      = names_left;
    tuple_net_next       = tuple_net;
    dnode_next           = dnode;
    dnet_next            = dnet;
    snode_next           = snode;
    snet_next            = snet;
    items                = '0;
    k                    = '0;
    reject_now           = 1'b0;
    end_pkt              = 1'b0;
    mark_last            = 1'b0;
    pl_full = {packet_length[9:8], item.in_byte};
    nl = direction_held ? {1'b0, pl_full - ddp_slhc_pkg::HDR_DELTA}
                        : {1'b0, pl_full} + {1'b0, ddp_slhc_pkg::HDR_DELTA};

    if (rejecting) begin
      // Drop bytes of a rejected packet until its end
      end_pkt = item.in_last;
    end else begin
      if (pos == POS_LEN_HI) begin
        direction_held_next = item.op;
        dnode_next = item.dst_node;
        dnet_next  = (item.dst_node == ddp_slhc_pkg::BCAST_NODE) ? 16'd0 : item.dst_net;
        snode_next = item.source_node;
        snet_next  = item.src_net;
        packet_length_next = {item.in_byte[1:0], 8'h00};
      end else if (pos == POS_LEN_LO) begin
        packet_length_next = pl_full;
        if (nl > out_limit) begin
          reject_now = 1'b1;
          items[0].out_status = 1'b1;
          k = ddp_slhc_pkg::CNT_W'(1);
        end else begin
          items[0].out_byte = {5'd0, nl[10:8]};
          items[1].out_byte = nl[7:0];
          k = ddp_slhc_pkg::CNT_W'(2);
        end
      end else if (!direction_held) begin
        if (pos == POS_S_DSK) begin
          // Expand into checksum, nets and nodes ahead of the socket byte
          items[2].out_byte = dnet[15:8];
          items[3].out_byte = dnet[7:0];
          items[4].out_byte = snet[15:8];
          items[5].out_byte = snet[7:0];
          items[6].out_byte = dnode;
          items[7].out_byte = snode;
          items[8].out_byte = item.in_byte;
          k = ddp_slhc_pkg::CNT_W'(9);
        end else if (pos == POS_S_SSK) begin
          items[0].out_byte = item.in_byte;
          k = ddp_slhc_pkg::CNT_W'(1);
        end else if (pos == POS_S_TYPE) begin
          is_nbp_next    = (item.in_byte == ddp_slhc_pkg::NBP_TYPE);
          nbp_phase_next = PH_COUNT;
          tuple_net_next = snet;
          items[0].out_byte = item.in_byte;
          k = ddp_slhc_pkg::CNT_W'(1);
        end else begin
          items[0].out_byte = is_nbp ? nbp_out : item.in_byte;
          k = ddp_slhc_pkg::CNT_W'(1);
          if (is_nbp) begin
            is_nbp_next          = n_is_nbp;
            nbp_phase_next       = n_phase;
            tuples_left_next     = n_tuples;
            name_bytes_left_next = n_nbl;
            names_left_next      = n_names;
          end
        end
      end else begin
        if (pos == POS_L_DSK || pos == POS_L_SSK) begin
          items[0].out_byte = item.in_byte;
          k = ddp_slhc_pkg::CNT_W'(1);
        end else if (pos == POS_L_TYPE) begin
          is_nbp_next    = (item.in_byte == ddp_slhc_pkg::NBP_TYPE);
          nbp_phase_next = PH_COUNT;
          tuple_net_next = 16'd0;
          items[0].out_byte = item.in_byte;
          k = ddp_slhc_pkg::CNT_W'(1);
        end else if (pos > POS_L_TYPE) begin
          items[0].out_byte = is_nbp ? nbp_out : item.in_byte;
          k = ddp_slhc_pkg::CNT_W'(1);
          if (is_nbp) begin
            is_nbp_next          = n_is_nbp;
            nbp_phase_next       = n_phase;
            tuples_left_next     = n_tuples;
            name_bytes_left_next = n_nbl;
            names_left_next      = n_names;
          end
        end
      end

      if (reject_now) begin
        mark_last = 1'b1;
        if (item.in_last) begin
          end_pkt = 1'b1;
        end else begin
          rejecting_next = 1'b1;
          pos_next       = POS_S_DSK;
        end
      end else begin
        pos_next = (pos != ddp_slhc_pkg::POS_MAX) ? pos + 11'd1 : ddp_slhc_pkg::POS_MAX;
        if (item.in_last) begin
          // A packet cut off with nothing due still ends in a status result
          if (k == '0) begin
            items[0].out_status = 1'b1;
            k = ddp_slhc_pkg::CNT_W'(1);
          end
          mark_last = 1'b1;
          end_pkt   = 1'b1;
        end
      end
    end

    // Flag the final result of the packet
    for (int i = 0; i < ddp_slhc_pkg::MAX_RESULTS; i++) begin
      if (mark_last && k == ddp_slhc_pkg::CNT_W'(i + 1)) items[i].out_last = 1'b1;
    end

    if (end_pkt) begin
      pos_next             = '0;
      packet_length_next   = '0;
      rejecting_next       = 1'b0;
      is_nbp_next          = 1'b0;
      nbp_phase_next       = PH_COUNT;
      tuples_left_next     = '0;
      name_bytes_left_next = '0;
      names_left_next      = '0;
    end

    res.count = k;
    res.items = items;
  end

  // Hold packet state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      packet_length   <= '0;
      direction_held  <= 1'b0;
      rejecting       <= 1'b0;
      is_nbp          <= 1'b0;
      nbp_phase       <= PH_COUNT;
      tuples_left     <= '0;
      name_bytes_left <= '0;
      names_left      <= '0;
    end else if (accept) begin
      pos             <= pos_next;
      packet_length   <= packet_length_next;
      direction_held  <= direction_held_next;
      rejecting       <= rejecting_next;
      is_nbp          <= is_nbp_next;
      nbp_phase       <= nbp_phase_next;
      tuples_left     <= tuples_left_next;
      name_bytes_left <= name_bytes_left_next;
      names_left      <= names_left_next;
    end
    if (accept) begin
      tuple_net <= tuple_net_next;
      dnode     <= dnode_next;
      dnet      <= dnet_next;
      snode     <= snode_next;
      snet      <= snet_next;
    end
  end

endmodule

// File: hw/rtl/ddp_short_long_header_converter.sv
// Latency: the first result of a byte is offered the cycle after the byte is accepted.
// Throughput: one byte per cycle while the result buffer is empty or emptying; a byte
//   with n results holds the input until the buffer, which drains one result per cycle
//   while result_ready is high, holds only one (9 for a short destination socket byte, 2 for the length low byte).
// Reset: synchronous, active high; clears packet state and the result buffer and sets
//   out_limit to 2047.
`include "ddp_short_long_header_converter_assert.svh"

module ddp_short_long_header_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [10:0]         cfg_wr_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  ddp_slhc_pkg::in_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output ddp_slhc_pkg::out_t  result
);

  logic [10:0]                    out_limit;
  logic [ddp_slhc_pkg::CNT_W-1:0] cnt;
  ddp_slhc_pkg::out_t             rbuf [ddp_slhc_pkg::MAX_RESULTS];
  ddp_slhc_pkg::res_set_t         res;
  logic                           load, pop;

  ddp_slhc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (load),
    .item      (item),
    .out_limit (out_limit),
    .res       (res)
  );

  // Take a new transaction once the buffer empties this cycle
  assign item_ready   = (cnt == '0) ||
                        (cnt == ddp_slhc_pkg::CNT_W'(1) && result_ready);
  assign load         = item_valid && item_ready;
  assign result_valid = (cnt != '0);
  assign pop          = result_valid && result_ready;
  assign result       = rbuf[0];

  // Hold the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= ddp_slhc_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      out_limit <= cfg_wr_data;
    end
  end

  // Load results of an accepted byte, else shift out one per taken result
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= res.count;
    end else if (pop) begin
      cnt <= cnt - ddp_slhc_pkg::CNT_W'(1);
    end
    if (load) begin
      for (int i = 0; i < ddp_slhc_pkg::MAX_RESULTS; i++) rbuf[i] <= res.items[i];
    end else if (pop) begin
      for (int i = 0; i < ddp_slhc_pkg::MAX_RESULTS - 1; i++) rbuf[i] <= rbuf[i + 1];
    end
  end

  `SLHC_ASSERT(a_status_ends, !(result_valid && result.out_status) || result.out_last, "status result without last")
  `SLHC_ASSERT(a_cnt_range, cnt <= ddp_slhc_pkg::CNT_W'(ddp_slhc_pkg::MAX_RESULTS), "result count overflow")
  `SLHC_ASSERT_NEXT(a_load_shows, load && res.count != '0, result_valid, "loaded results not offered")

endmodule

// File: verif/tb_ddp_short_long_header_converter.sv
`timescale 1ns / 100ps

module tb_ddp_short_long_header_converter;
  import ddp_slhc_pkg::*;

  localparam logic OP_S2L    = 1'b0;
  localparam logic OP_L2S    = 1'b1;
  localparam logic ST_DATA   = 1'b0;
  localparam logic ST_STATUS = 1'b1;

  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_STALL   = 150;
  localparam int PHASE_ITEMS  = 125;
  localparam int TIMEOUT_NS   = 3_000_000;

  // One directed transaction, with an optional limit write ahead of it and an
  // optional hand-typed single result
  typedef struct {
    bit          cfg;
    logic [10:0] lim;
    logic        op;
    logic [7:0]  b;
    logic        last;
    logic [7:0]  dnode;
    logic [15:0] dnet;
    logic [7:0]  snode;
    logic [15:0] snet;
    bit          typed;
    logic [7:0]  wb;
    logic        wl;
    logic        ws;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        item_valid;
  logic        item_ready;
  in_t         item;
  logic        result_valid;
  logic        result_ready;
  out_t        result;

  // Sender and receiver controls
  bit   idle_on;
  bit   stall_req;
  bit   use_typed;
  out_t typed_want;

  // Converter state as seen by the checker
  logic [10:0] limit_q;
  logic [10:0] pos_q;
  logic [9:0]  len_q;
  logic        dir_q;
  bit          drop_pkt;
  bit          nbp_on;
  logic [2:0]  nbp_step;
  logic [3:0]  tuples_rem;
  logic [7:0]  name_rem;
  logic [1:0]  names_rem;
  logic [15:0] tuple_net_q;
  logic [7:0]  h_dnode;
  logic [15:0] h_dnet;
  logic [7:0]  h_snode;
  logic [15:0] h_snet;

  out_t byte_results[$];
  out_t due_results[$];
  in_t  pkt_q[$];

  int err_cnt;
  int sent_items;
  int acc_items;
  int got_results;
  int status_seen;
  int pkt_cnt;
  int nbp_pkts;
  int limit_writes;

  stim_row_t dir_tbl [24] = '{
    '{0, 11'd0, OP_L2S, 8'hff, 1, 8'hff, 16'hffff, 8'hff, 16'hffff, 1, 8'h00, 1, ST_STATUS},
    '{0, 11'd0, OP_S2L, 8'hfc, 0, 8'hff, 16'habcd, 8'h00, 16'hffff, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h10, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h00, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'hff, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, NBP_TYPE, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h21, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h7e, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h55, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'haa, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h00, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'hff, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h01, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h00, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h00, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h00, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'hff, 1, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_L2S, 8'h03, 0, 8'h12, 16'h3456, 8'h78, 16'h9abc, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_L2S, 8'h05, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_L2S, 8'h00, 1, 8'h00, 16'h0000, 8'h00, 16'h0000, 1, 8'h00, 1, ST_STATUS},
    '{1, 11'd0, OP_S2L, 8'h00, 0, 8'h5a, 16'h1234, 8'ha5, 16'h4321, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'h08, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 1, 8'h00, 1, ST_STATUS},
    '{0, 11'd0, OP_S2L, 8'h00, 0, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA},
    '{0, 11'd0, OP_S2L, 8'hff, 1, 8'h00, 16'h0000, 8'h00, 16'h0000, 0, 8'h00, 0, ST_DATA}
  };

  ddp_short_long_header_converter u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #4 clk = ~clk;

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Return the walk to the start of a packet
  function automatic void clear_packet();
    pos_q      = '0;
    len_q      = '0;
    drop_pkt   = 1'b0;
    nbp_on     = 1'b0;
    nbp_step   = '0;
    tuples_rem = '0;
    name_rem   = '0;
    names_rem  = '0;
  endfunction

  function automatic void emit(logic [7:0] b, logic st);
    out_t r;
    r.out_byte   = b;
    r.out_last   = 1'b0;
    r.out_status = st;
    byte_results.push_back(r);
  endfunction

  function automatic void tuple_end();
    tuples_rem = tuples_rem - 4'd1;
    if (tuples_rem == 0) begin
      nbp_on = 1'b0;
    end else begin
      nbp_step = 3'd2;
    end
  endfunction

  // Walk one NBP byte; rewrite the tuple net and skip the three names
  function automatic logic [7:0] nbp_xlate(logic [7:0] b);
    case (nbp_step)
      3'd0: begin
        tuples_rem = b[3:0] & COUNT_MASK;
        if (tuples_rem == 0) nbp_on = 1'b0;
        else nbp_step = 3'd1;
        return b;
      end
      3'd1: begin
        nbp_step = 3'd2;
        return b;
      end
      3'd2: begin
        nbp_step = 3'd3;
        return tuple_net_q[15:8];
      end
      3'd3: begin
        nbp_step = 3'd4;
        return tuple_net_q[7:0];
      end
      3'd4, 3'd5: begin
        nbp_step = nbp_step + 3'd1;
        return b;
      end
      3'd6: begin
        nbp_step  = 3'd7;
        names_rem = 2'd3;
        name_rem  = 8'd0;
        return b;
      end
      default: begin
        if (name_rem == 0) begin
          names_rem = names_rem - 2'd1;
          name_rem  = b;
          if (b == 0 && names_rem == 0) tuple_end();
        end else begin
          name_rem = name_rem - 8'd1;
          if (name_rem == 0 && names_rem == 0) tuple_end();
        end
        return b;
      end
    endcase
  endfunction

  function automatic void type_seen(logic [7:0] b);
    nbp_on      = (b == NBP_TYPE);
    nbp_step    = 3'd0;
    tuple_net_q = dir_q ? 16'h0000 : h_snet;
  endfunction

  function automatic logic [7:0] body_byte(logic [7:0] b);
    if (nbp_on) return nbp_xlate(b);
    return b;
  endfunction

  // Work out every result one accepted byte causes
  function automatic void convert_byte(in_t it);
    logic [10:0] p;
    logic [10:0] new_len;
    byte_results.delete();
    if (drop_pkt) begin
      if (it.in_last) clear_packet();
      return;
    end
    p = pos_q;
    if (p == 0) begin
      dir_q   = it.op;
      h_dnode = it.dst_node;
      h_dnet  = (it.dst_node == BCAST_NODE) ? 16'h0000 : it.dst_net;
      h_snode = it.source_node;
      h_snet  = it.src_net;
      len_q   = {it.in_byte[1:0], 8'h00};
    end else if (p == 1) begin
      len_q[7:0] = it.in_byte;
      if (dir_q == OP_S2L) new_len = {1'b0, len_q} + {1'b0, HDR_DELTA};
      else new_len = {1'b0, len_q - HDR_DELTA};
      // reject: one status result, then drop the rest of the packet
      if (new_len > limit_q) begin
        emit(8'h00, ST_STATUS);
        byte_results[0].out_last = 1'b1;
        if (it.in_last) begin
          clear_packet();
        end else begin
          drop_pkt = 1'b1;
          pos_q    = 11'd2;
        end
        return;
      end
      emit(dir_q ? {6'd0, new_len[9:8]} : {5'd0, new_len[10:8]}, ST_DATA);
      emit(new_len[7:0], ST_DATA);
    end else if (dir_q == OP_S2L) begin
      if (p == 2) begin
        emit(8'h00, ST_DATA);
        emit(8'h00, ST_DATA);
        emit(h_dnet[15:8], ST_DATA);
        emit(h_dnet[7:0], ST_DATA);
        emit(h_snet[15:8], ST_DATA);
        emit(h_snet[7:0], ST_DATA);
        emit(h_dnode, ST_DATA);
        emit(h_snode, ST_DATA);
        emit(it.in_byte, ST_DATA);
      end else if (p == 3) begin
        emit(it.in_byte, ST_DATA);
      end else if (p == 4) begin
        type_seen(it.in_byte);
        emit(it.in_byte, ST_DATA);
      end else begin
        emit(body_byte(it.in_byte), ST_DATA);
      end
    end else begin
      if (p == 10 || p == 11) begin
        emit(it.in_byte, ST_DATA);
      end else if (p == 12) begin
        type_seen(it.in_byte);
        emit(it.in_byte, ST_DATA);
      end else if (p > 12) begin
        emit(body_byte(it.in_byte), ST_DATA);
      end
    end
    pos_q = (p < POS_MAX) ? p + 11'd1 : POS_MAX;
    if (it.in_last) begin
      if (byte_results.size() == 0) emit(8'h00, ST_STATUS);
      byte_results[byte_results.size() - 1].out_last = 1'b1;
      clear_packet();
    end
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_item(in_t it, bit typed, out_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    item       = it;
    use_typed  = typed;
    typed_want = want;
    item_valid = 1'b1;
    sent_items++;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(logic [10:0] v);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    limit_q     = v;
    limit_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Build one packet: mostly well-formed, some with a random length word,
  // some cut short, some plain noise
  task automatic make_packet();
    logic [7:0] bytes[$];
    logic [7:0] body[$];
    logic [9:0] lenf;
    logic       dir;
    int         kind;
    int         ntup;
    int         nl;
    int         maxl;
    in_t        it;
    pkt_q.delete();
    dir  = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 7);
    if (kind == 0) begin
      repeat ($urandom_range(1, 16)) bytes.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        ntup = ($urandom_range(0, 15) == 0) ? 15 : $urandom_range(0, 3);
        maxl = (ntup > 3) ? 1 : 4;
        body.push_back(NBP_TYPE);
        body.push_back({4'($urandom), 4'(ntup)});
        body.push_back(8'($urandom));
        repeat (ntup) begin
          repeat (5) body.push_back(8'($urandom));
          repeat (3) begin
            nl = $urandom_range(0, maxl);
            body.push_back(8'(nl));
            repeat (nl) body.push_back(8'($urandom));
          end
        end
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        nbp_pkts++;
      end else begin
        repeat ($urandom_range(1, 13)) body.push_back(8'($urandom));
      end
      lenf = 10'(body.size() + (dir ? 12 : 4));
      if (kind == 1) lenf = 10'($urandom);
      bytes.push_back({6'($urandom), lenf[9:8]});
      bytes.push_back(lenf[7:0]);
      repeat (dir ? 10 : 2) bytes.push_back(8'($urandom));
      bytes = {bytes, body};
      if (kind == 2) bytes = bytes[0 : $urandom_range(0, bytes.size() - 1)];
    end
    foreach (bytes[i]) begin
      it.op          = (i == 0) ? dir : 1'($urandom);
      it.in_byte     = bytes[i];
      it.in_last     = (i == bytes.size() - 1);
      it.dst_node    = (i == 0 && $urandom_range(0, 3) == 0) ? BCAST_NODE : 8'($urandom);
      it.dst_net     = 16'($urandom);
      it.source_node = 8'($urandom);
      it.src_net     = 16'($urandom);
      pkt_q.push_back(it);
    end
    pkt_cnt++;
  endtask

  // Predict on accepted input, check accepted output
  always @(posedge clk) begin : check_side
    out_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        acc_items++;
        convert_byte(item);
        if (use_typed) due_results.push_back(typed_want);
        else foreach (byte_results[i]) due_results.push_back(byte_results[i]);
      end
      if (result_valid && result_ready) begin
        got_results++;
        if (result.out_status) status_seen++;
        if (due_results.size() == 0) begin
          note_error($sformatf("unexpected result byte=%02h last=%b status=%b",
                               result.out_byte, result.out_last, result.out_status));
        end else begin
          want = due_results.pop_front();
          if (result.out_byte !== want.out_byte || result.out_last !== want.out_last ||
              result.out_status !== want.out_status)
            note_error($sformatf(
              "result %0d: expected byte=%02h last=%b status=%b, got byte=%02h last=%b status=%b",
              got_results, want.out_byte, want.out_last, want.out_status,
              result.out_byte, result.out_last, result.out_status));
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_side
    int gap;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        result_ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_req    = 1'b0;
        result_ready = 1'b1;
      end else if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
        result_ready = 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap - 1) @(negedge clk);
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   r;
    in_t         it;
    out_t        want;
    logic [10:0] lim;
    int          target;
    bit          held_once;
    bit          paused_once;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    item_valid  = 1'b0;
    item        = '0;
    use_typed   = 1'b0;
    typed_want  = '0;
    idle_on     = 1'b1;
    stall_req   = 1'b0;
    held_once   = 1'b0;
    paused_once = 1'b0;
    limit_q     = LIMIT_RESET;
    dir_q       = 1'b0;
    tuple_net_q = '0;
    h_dnode     = '0;
    h_dnet      = '0;
    h_snode     = '0;
    h_snet      = '0;
    clear_packet();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (dir_tbl[i]) begin
      r = dir_tbl[i];
      if (r.cfg) set_limit(r.lim);
      it   = '{op: r.op, in_byte: r.b, in_last: r.last, dst_node: r.dnode,
               dst_net: r.dnet, source_node: r.snode, src_net: r.snet};
      want = '{out_byte: r.wb, out_last: r.wl, out_status: r.ws};
      send_item(it, r.typed, want);
    end

    // Random packets under several limit settings; no idling in the last phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: lim = LIMIT_RESET;
        1: lim = 11'($urandom_range(16, 48));
        2: lim = 11'($urandom_range(0, 2047));
        default: lim = LIMIT_RESET;
      endcase
      set_limit(lim);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        idle_on = (ph < 3) && ($urandom_range(0, 3) != 0);
        // hold the result side off while bytes keep coming
        if (ph == 0 && !held_once && pkt_cnt > 2) begin
          idle_on   = 1'b0;
          stall_req = 1'b1;
          held_once = 1'b1;
        end
        // pause the input until every result is out
        if (ph == 1 && !paused_once && sent_items > target - PHASE_ITEMS / 2) begin
          wait_drained();
          paused_once = 1'b1;
        end
        make_packet();
        foreach (pkt_q[i]) send_item(pkt_q[i], 1'b0, '0);
      end
    end

    // Drain and settle
    for (int n = 0; n < 5000 && due_results.size() != 0; n++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_results.size() != 0)
      note_error($sformatf("%0d expected results never arrived", due_results.size()));

    $display("Sent %0d bytes in %0d packets (%0d NBP) across %0d limit settings",
             acc_items, pkt_cnt, nbp_pkts, limit_writes);
    $display("Checked %0d results, %0d of them status; %0d mismatches",
             got_results, status_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: run did not finish, %0d results still due", due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
